// File: sv/pml_pkg.sv
// pml_pkg: shared types, constants and helpers for the pattern match line reporter
// no dependencies; imported by every module of the block
package pml_pkg;

    // sizing
    localparam int MAX_PATTERN = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int OUT_W       = 32;
    localparam int CFG_W       = 64;
    localparam int PLEN_W      = 5;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2
    } cfg_index_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [LEN_W-1:0]       len_t;

    localparam count_t COUNT_MAX = '1;

    // classified byte handed from front to back
    typedef struct packed {
        logic                   valid;
        logic                   hit;
        logic                   last;
        count_t                 line_cnt;
        logic [MAX_PATTERN-1:0] later_mask;
    } front_item_t;

    // one result beat
    typedef struct packed {
        logic             match_found;
        logic             text_done;
        logic [OUT_W-1:0] match_line;
        logic [OUT_W-1:0] occurrence_total;
    } result_t;

    // byte i of the 16-byte pattern, byte 0 in bits 7:0
    function automatic logic [7:0] pat_byte(logic [127:0] pat, logic [3:0] i);
        return pat[{i, 3'b000} +: 8];
    endfunction

    // saturate a counter value to the 32-bit result field
    function automatic logic [OUT_W-1:0] clip_out(count_t v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[OUT_W-1:0];
    endfunction

endpackage

// File: sv/pattern_match_line_reporter.sv
// pattern_match_line_reporter: top level; depends on pml_pkg, pml_front, pml_back, pml_fifo
// path: front beat register, then the result queue, whose head drives the output ports
// throughput: one text byte per cycle unless full; the whole window is compared in parallel
// full rises when the result queue plus the beat in flight fill its four entries
// reset: asynchronous, active low; pattern registers, window, line and occurrence
// counters return to their reset values at once, with no clearing pass
module pattern_match_line_reporter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                text_byte,
    input  logic                      end_of_text,
    output logic                      empty,
    input  logic                      pop,
    output logic                      match_found,
    output logic                      text_done,
    output logic [31:0]               match_line,
    output logic [31:0]               occurrence_total,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [pml_pkg::CFG_W-1:0] cfg_data
);
    import pml_pkg::*;

    front_item_t           item;
    logic                  res_push;
    result_t               res_data;
    result_t               head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                  accept;

    // room for one more beat counting the one in flight
    assign full   = (FIFO_CNT_W'(fifo_count + FIFO_CNT_W'(item.valid)) >=
                     FIFO_CNT_W'(FIFO_DEPTH));
    assign accept = push && !full;

    pml_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (item)
    );

    pml_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .res_push (res_push),
        .res_data (res_data)
    );

    pml_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .pop       (pop),
        .empty     (empty),
        .head      (head),
        .count     (fifo_count)
    );

    // result ports
    assign match_found      = head.match_found;
    assign text_done        = head.text_done;
    assign match_line       = head.match_line;
    assign occurrence_total = head.occurrence_total;

endmodule

// File: sv/pml_front.sv
// pml_front: configuration registers, byte window, line counter and match compare
// depends on pml_pkg
module pml_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                text_byte,
    input  logic                      end_of_text,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [pml_pkg::CFG_W-1:0] cfg_data,
    output pml_pkg::front_item_t      item
);
    import pml_pkg::*;

    logic [63:0]       pat_low_reg;
    logic [63:0]       pat_high_reg;
    logic [PLEN_W-1:0] pat_len_reg;

    logic [7:0]             window_reg [MAX_PATTERN];
    logic [7:0]             window_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] marks_reg;
    logic [MAX_PATTERN-1:0] marks_next;
    len_t                   fill_reg;
    len_t                   fill_next;
    count_t                 line_reg;
    count_t                 line_next;
    front_item_t            item_reg;
    front_item_t            item_next;

    logic [127:0] pattern;
    len_t         used;
    logic         hit;
    logic         is_nl;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= PLEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  pat_low_reg  <= cfg_data[63:0];
                CFG_PATTERN_HIGH: pat_high_reg <= cfg_data[63:0];
                CFG_PATTERN_LEN:  pat_len_reg  <= cfg_data[PLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective pattern length, clamped to 1..MAX_PATTERN
    always_comb
    begin
        pattern = {pat_high_reg, pat_low_reg};
        if (pat_len_reg == '0)
            used = LEN_W'(1);
        else if (pat_len_reg > PLEN_W'(MAX_PATTERN))
            used = LEN_W'(MAX_PATTERN);
        else
            used = LEN_W'(pat_len_reg);
    end

    // window shift, line count and parallel compare
    always_comb
    begin
        logic [4:0] pidx;
        pidx  = '0;
        is_nl = (text_byte == NEWLINE_BYTE);

        window_next[0] = text_byte;
        marks_next[0]  = is_nl;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            window_next[k] = window_reg[k-1];
            marks_next[k]  = marks_reg[k-1];
        end

        fill_next = (fill_reg == LEN_W'(MAX_PATTERN)) ? fill_reg : fill_reg + LEN_W'(1);

        line_next = line_reg;
        if (is_nl && line_reg != COUNT_MAX)
            line_next = line_reg + count_t'(1);

        // newest byte in slot 0 lines up with the last pattern byte
        hit = (fill_next >= used);
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            pidx = 5'(used) - 5'd1 - 5'(k);
            if (k < int'(used) && window_next[k] != pat_byte(pattern, pidx[3:0]))
                hit = 1'b0;
        end

        item_next.valid    = accept;
        item_next.hit      = hit;
        item_next.last     = end_of_text;
        item_next.line_cnt = line_next;
        for (int k = 0; k < MAX_PATTERN; k++)
            item_next.later_mask[k] = marks_next[k] && (k + 1 < int'(used));
    end

    // stream state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
                window_reg[k] <= '0;
            marks_reg <= '0;
            fill_reg  <= '0;
            line_reg  <= count_t'(1);
        end
        else if (accept)
        begin
            if (end_of_text)
            begin
                for (int k = 0; k < MAX_PATTERN; k++)
                    window_reg[k] <= '0;
                marks_reg <= '0;
                fill_reg  <= '0;
                line_reg  <= count_t'(1);
            end
            else
            begin
                for (int k = 0; k < MAX_PATTERN; k++)
                    window_reg[k] <= window_next[k];
                marks_reg <= marks_next;
                fill_reg  <= fill_next;
                line_reg  <= line_next;
            end
        end
    end

    // classified beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else
            item_reg <= item_next;
    end

    assign item = item_reg;

endmodule

// File: sv/pml_back.sv
// pml_back: line of the match start, occurrence counter and result formation
// depends on pml_pkg
module pml_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pml_pkg::front_item_t  item,
    output logic                  res_push,
    output pml_pkg::result_t      res_data
);
    import pml_pkg::*;

    count_t match_reg;
    count_t match_next;
    len_t   later;
    count_t line;

    // newlines inside the match, then line of its first byte
    always_comb
    begin
        later = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
            later = later + LEN_W'(item.later_mask[k]);

        if (item.line_cnt == COUNT_MAX)
            line = COUNT_MAX;
        else
            line = item.line_cnt - count_t'(later);

        match_next = match_reg;
        if (item.hit && match_reg != COUNT_MAX)
            match_next = match_reg + count_t'(1);

        res_push                  = item.valid && (item.hit || item.last);
        res_data.match_found      = item.hit;
        res_data.text_done        = item.last;
        res_data.match_line       = item.hit ? clip_out(line) : '0;
        res_data.occurrence_total = clip_out(match_next);
    end

    // occurrence counter, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= '0;
        else if (item.valid)
            match_reg <= item.last ? '0 : match_next;
    end

endmodule

// File: sv/pml_fifo.sv
// pml_fifo: short result queue between the back part and the output port
// depends on pml_pkg
module pml_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  pml_pkg::result_t                    push_data,
    input  logic                                pop,
    output logic                                empty,
    output pml_pkg::result_t                    head,
    output logic [pml_pkg::FIFO_CNT_W-1:0]      count
);
    import pml_pkg::*;

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_pop;

    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = mem_reg[rd_ptr_reg];
    assign count  = count_reg;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            if (push && !do_pop)
                count_reg <= count_reg + FIFO_CNT_W'(1);
            else if (!push && do_pop)
                count_reg <= count_reg - FIFO_CNT_W'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
